// ----- rtl/pcbs_pkg.sv -----
`timescale 1ns / 1ps
package pcbs_pkg;

  localparam int STACK_DEPTH = 64;
  localparam int POS_BITS    = 24;
  localparam int COUNT_BITS  = 12;

  localparam int OFF_W  = 24;
  localparam int ARG_W  = 13;
  localparam int IDX_W  = $clog2(STACK_DEPTH);
  localparam int SCNT_W = $clog2(STACK_DEPTH + 1);

  localparam int QUEUE_DEPTH = 4;
  localparam int QPTR_W      = $clog2(QUEUE_DEPTH);
  localparam int QCNT_W      = $clog2(QUEUE_DEPTH + 1);

  typedef enum logic [2:0] {
    OP_NOP,
    OP_TOKEN,
    OP_PUSH,
    OP_POP,
    OP_COMMA
  } op_t;

  typedef enum logic {
    KIND_LINE  = 1'b0,
    KIND_PAREN = 1'b1
  } kind_t;

  // classified byte handed from front to back
  typedef struct packed {
    logic                  newline;
    op_t                   op;
    logic [POS_BITS-1:0]   pos;
    logic [COUNT_BITS-1:0] square;
    logic [COUNT_BITS-1:0] curly;
    logic                  last;
  } scan_item_t;

  typedef struct packed {
    logic [POS_BITS-1:0]   open_pos;
    logic [COUNT_BITS-1:0] commas;
    logic [COUNT_BITS-1:0] square;
    logic [COUNT_BITS-1:0] curly;
    logic                  tok_seen;
  } frame_t;

  localparam int FRAME_W = $bits(frame_t);

endpackage

// ----- rtl/pcbs_in_if.sv -----
`timescale 1ns / 1ps
interface pcbs_in_if;
  logic       valid;
  logic       ready;
  logic [7:0] text_byte;
  logic       end_of_text;

  modport source(output valid, text_byte, end_of_text, input ready);
  modport sink(input valid, text_byte, end_of_text, output ready);
endinterface

// ----- rtl/pcbs_out_if.sv -----
`timescale 1ns / 1ps
interface pcbs_out_if;
  logic                     valid;
  logic                     ready;
  logic                     result_kind;
  logic [pcbs_pkg::OFF_W-1:0] open_offset;
  logic [pcbs_pkg::OFF_W-1:0] mark_offset;
  logic [pcbs_pkg::ARG_W-1:0] arg_count;
  logic                     stack_overflowed;

  modport source(output valid, result_kind, open_offset, mark_offset, arg_count,
                 stack_overflowed, input ready);
  modport sink(input valid, result_kind, open_offset, mark_offset, arg_count,
               stack_overflowed, output ready);
endinterface

// ----- rtl/paren_call_boundary_scanner.sv -----
`timescale 1ns / 1ps
// Channel     Modport  Item fields
// text_in     sink     text_byte[7:0], end_of_text
// result_out  source   result_kind, open_offset[23:0], mark_offset[23:0],
//                      arg_count[12:0], stack_overflowed
//
// One text byte is taken per cycle unless the queue is full; each result is registered
// after its byte passes the front (classifies), the four-deep queue and the stack side.
// The stack keeps its top frame in flops and the rest in a single-port-write RAM whose
// next-down entry is prefetched each cycle, so pushes and pops run back to back.
// Synchronous reset clears all control state; no clearing pass of the frame RAM.
// A stalled result_out holds the stack side; text_in stalls only once the queue fills.
module paren_call_boundary_scanner (
  input  logic        clk,
  input  logic        rst,
  pcbs_in_if.sink     text_in,
  pcbs_out_if.source  result_out
);

  logic                 enq_valid, enq_ready;
  pcbs_pkg::scan_item_t enq_item;
  logic                 deq_valid, deq_pop;
  pcbs_pkg::scan_item_t deq_item;

  pcbs_front u_front (
    .clk       (clk),
    .rst       (rst),
    .text_in   (text_in),
    .enq_valid (enq_valid),
    .enq_item  (enq_item),
    .enq_ready (enq_ready)
  );

  pcbs_queue u_queue (
    .clk       (clk),
    .rst       (rst),
    .enq_valid (enq_valid),
    .enq_item  (enq_item),
    .enq_ready (enq_ready),
    .deq_valid (deq_valid),
    .deq_item  (deq_item),
    .deq_pop   (deq_pop)
  );

  pcbs_back u_back (
    .clk        (clk),
    .rst        (rst),
    .deq_valid  (deq_valid),
    .deq_item   (deq_item),
    .deq_pop    (deq_pop),
    .result_out (result_out)
  );

endmodule

// ----- rtl/pcbs_ram.sv -----
`timescale 1ns / 1ps
module pcbs_ram #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 16
) (
  input  logic                     clk,
  input  logic                     we,
  input  logic [$clog2(DEPTH)-1:0] waddr,
  input  logic [WIDTH-1:0]         wdata,
  input  logic [$clog2(DEPTH)-1:0] raddr,
  output logic [WIDTH-1:0]         rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    rdata <= mem[raddr];
  end

endmodule

// ----- rtl/pcbs_front.sv -----
`timescale 1ns / 1ps
module pcbs_front (
  input  logic                 clk,
  input  logic                 rst,
  pcbs_in_if.sink              text_in,
  output logic                 enq_valid,
  output pcbs_pkg::scan_item_t enq_item,
  input  logic                 enq_ready
);

  localparam logic [7:0] CH_HASH   = 8'h23;
  localparam logic [7:0] CH_QUOTE  = 8'h22;
  localparam logic [7:0] CH_BSLASH = 8'h5C;
  localparam logic [7:0] CH_LPAREN = 8'h28;
  localparam logic [7:0] CH_RPAREN = 8'h29;
  localparam logic [7:0] CH_LSQ    = 8'h5B;
  localparam logic [7:0] CH_RSQ    = 8'h5D;
  localparam logic [7:0] CH_LCURLY = 8'h7B;
  localparam logic [7:0] CH_RCURLY = 8'h7D;
  localparam logic [7:0] CH_COMMA  = 8'h2C;
  localparam logic [7:0] CH_NL     = 8'h0A;

  localparam logic [pcbs_pkg::COUNT_BITS-1:0] CNT_MAX = '1;

  logic [pcbs_pkg::POS_BITS-1:0]   pos, pos_next;
  logic                            comment_on, comment_on_next;
  logic                            quote_on, quote_on_next;
  logic                            escape, escape_next;
  logic [pcbs_pkg::COUNT_BITS-1:0] square, square_next;
  logic [pcbs_pkg::COUNT_BITS-1:0] curly, curly_next;
  logic                            accept;
  logic [7:0]                      c;
  pcbs_pkg::op_t                   op;

  assign text_in.ready = enq_ready;
  assign accept        = text_in.valid && enq_ready;
  assign c             = text_in.text_byte;

  always_comb begin
    comment_on_next = comment_on;
    quote_on_next   = quote_on;
    escape_next     = escape;
    square_next     = square;
    curly_next      = curly;
    op              = pcbs_pkg::OP_NOP;
    if (comment_on) begin
      if (c == CH_NL) begin
        comment_on_next = 1'b0;
      end
    end else if (quote_on) begin
      if (escape) begin
        escape_next = 1'b0;
      end else if (c == CH_BSLASH) begin
        escape_next = 1'b1;
      end else if (c == CH_QUOTE) begin
        quote_on_next = 1'b0;
      end
    end else begin
      case (c)
        CH_HASH: comment_on_next = 1'b1;
        CH_QUOTE: begin
          quote_on_next = 1'b1;
          op            = pcbs_pkg::OP_TOKEN;
        end
        CH_LPAREN: op = pcbs_pkg::OP_PUSH;
        CH_RPAREN: op = pcbs_pkg::OP_POP;
        CH_COMMA:  op = pcbs_pkg::OP_COMMA;
        CH_LSQ: begin
          if (square != CNT_MAX) square_next = square + 1'b1;
          op = pcbs_pkg::OP_TOKEN;
        end
        CH_RSQ: begin
          if (square != '0) square_next = square - 1'b1;
          op = pcbs_pkg::OP_TOKEN;
        end
        CH_LCURLY: begin
          if (curly != CNT_MAX) curly_next = curly + 1'b1;
          op = pcbs_pkg::OP_TOKEN;
        end
        CH_RCURLY: begin
          if (curly != '0) curly_next = curly - 1'b1;
          op = pcbs_pkg::OP_TOKEN;
        end
        default: begin
          if (!(c inside {8'h20, [8'h09:8'h0D]})) op = pcbs_pkg::OP_TOKEN;
        end
      endcase
    end
    pos_next = pos + 1'b1;
  end

  always_comb begin
    enq_item.newline = (c == CH_NL);
    enq_item.op      = op;
    enq_item.pos     = pos;
    enq_item.square  = square;
    enq_item.curly   = curly;
    enq_item.last    = text_in.end_of_text;
    // drop bytes that leave nothing for the stack side to do
    enq_valid = accept && ((c == CH_NL) || (op != pcbs_pkg::OP_NOP) || text_in.end_of_text);
  end

  always_ff @(posedge clk) begin
    if (rst || (accept && text_in.end_of_text)) begin
      pos        <= '0;
      comment_on <= 1'b0;
      quote_on   <= 1'b0;
      escape     <= 1'b0;
      square     <= '0;
      curly      <= '0;
    end else if (accept) begin
      pos        <= pos_next;
      comment_on <= comment_on_next;
      quote_on   <= quote_on_next;
      escape     <= escape_next;
      square     <= square_next;
      curly      <= curly_next;
    end
  end

  assert property (@(posedge clk) disable iff (rst)
    escape |-> quote_on)
    else $error("escape pending outside a string");

endmodule

// ----- rtl/pcbs_queue.sv -----
`timescale 1ns / 1ps
module pcbs_queue (
  input  logic                 clk,
  input  logic                 rst,
  input  logic                 enq_valid,
  input  pcbs_pkg::scan_item_t enq_item,
  output logic                 enq_ready,
  output logic                 deq_valid,
  output pcbs_pkg::scan_item_t deq_item,
  input  logic                 deq_pop
);

  pcbs_pkg::scan_item_t            slots [pcbs_pkg::QUEUE_DEPTH];
  logic [pcbs_pkg::QPTR_W-1:0]     wr_ptr, rd_ptr;
  logic [pcbs_pkg::QCNT_W-1:0]     fill;
  logic                            do_enq, do_deq;

  assign enq_ready = (fill != pcbs_pkg::QCNT_W'(pcbs_pkg::QUEUE_DEPTH));
  assign deq_valid = (fill != '0);
  assign deq_item  = slots[rd_ptr];
  assign do_enq    = enq_valid && enq_ready;
  assign do_deq    = deq_pop && deq_valid;

  always_ff @(posedge clk) begin
    if (do_enq) begin
      slots[wr_ptr] <= enq_item;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      wr_ptr <= '0;
      rd_ptr <= '0;
      fill   <= '0;
    end else begin
      if (do_enq) wr_ptr <= wr_ptr + 1'b1;
      if (do_deq) rd_ptr <= rd_ptr + 1'b1;
      case ({do_enq, do_deq})
        2'b10:   fill <= fill + 1'b1;
        2'b01:   fill <= fill - 1'b1;
        default: fill <= fill;
      endcase
    end
  end

  assert property (@(posedge clk) disable iff (rst)
    fill <= pcbs_pkg::QCNT_W'(pcbs_pkg::QUEUE_DEPTH))
    else $error("queue fill beyond depth");

  assert property (@(posedge clk) disable iff (rst)
    (fill == '0) || (fill == pcbs_pkg::QCNT_W'(pcbs_pkg::QUEUE_DEPTH)) ||
    (wr_ptr != rd_ptr))
    else $error("queue pointers disagree with fill");

endmodule

// ----- rtl/pcbs_back.sv -----
`timescale 1ns / 1ps
module pcbs_back (
  input  logic                 clk,
  input  logic                 rst,
  input  logic                 deq_valid,
  input  pcbs_pkg::scan_item_t deq_item,
  output logic                 deq_pop,
  pcbs_out_if.source           result_out
);

  localparam logic [pcbs_pkg::COUNT_BITS-1:0] CNT_MAX = '1;
  localparam logic [pcbs_pkg::SCNT_W-1:0]     FULL    = pcbs_pkg::SCNT_W'(pcbs_pkg::STACK_DEPTH);

  logic [pcbs_pkg::SCNT_W-1:0] depth, depth_next;
  pcbs_pkg::frame_t            top, top_next, below, wr_frame, rd_frame, byp_frame;
  logic                        ovf, ovf_next;
  logic                        byp;
  logic                        we;
  logic [pcbs_pkg::IDX_W-1:0]  waddr, raddr;
  logic                        fire;
  logic                        res;
  logic                        res_kind;
  logic [pcbs_pkg::OFF_W-1:0]  res_open, res_mark;
  logic [pcbs_pkg::ARG_W-1:0]  res_args;
  logic                        out_valid;

  assign fire    = deq_valid && (!out_valid || result_out.ready);
  assign deq_pop = fire;
  assign below   = byp ? byp_frame : rd_frame;

  always_comb begin
    depth_next = depth;
    top_next   = top;
    ovf_next   = ovf;
    we         = 1'b0;
    wr_frame   = top;
    wr_frame.tok_seen = 1'b1;
    waddr      = pcbs_pkg::IDX_W'(depth - 1'b1);
    res        = 1'b0;
    res_kind   = pcbs_pkg::KIND_LINE;
    res_open   = '0;
    res_mark   = '0;
    res_args   = '0;
    if (fire) begin
      case (deq_item.op)
        pcbs_pkg::OP_TOKEN: begin
          if (depth != '0) top_next.tok_seen = 1'b1;
        end
        pcbs_pkg::OP_COMMA: begin
          if (depth != '0) begin
            if (deq_item.square == top.square && deq_item.curly == top.curly) begin
              if (top.commas != CNT_MAX) top_next.commas = top.commas + 1'b1;
            end else begin
              top_next.tok_seen = 1'b1;
            end
          end
        end
        pcbs_pkg::OP_PUSH: begin
          if (depth == FULL) begin
            // drop the paren; the enclosing frame still sees a token
            ovf_next          = 1'b1;
            top_next.tok_seen = 1'b1;
          end else begin
            we                = (depth != '0);
            top_next.open_pos = deq_item.pos;
            top_next.commas   = '0;
            top_next.square   = deq_item.square;
            top_next.curly    = deq_item.curly;
            top_next.tok_seen = 1'b0;
            depth_next        = depth + 1'b1;
          end
        end
        pcbs_pkg::OP_POP: begin
          if (depth != '0) begin
            res      = 1'b1;
            res_kind = pcbs_pkg::KIND_PAREN;
            res_open = pcbs_pkg::OFF_W'(top.open_pos);
            res_mark = pcbs_pkg::OFF_W'(deq_item.pos);
            res_args = top.tok_seen ?
                       pcbs_pkg::ARG_W'({1'b0, top.commas} + 1'b1) : '0;
            depth_next        = depth - 1'b1;
            top_next          = below;
            top_next.tok_seen = 1'b1;
          end
        end
        default: ;
      endcase
      if (deq_item.newline) begin
        res      = 1'b1;
        res_kind = pcbs_pkg::KIND_LINE;
        res_mark = pcbs_pkg::OFF_W'(deq_item.pos + 1'b1);
      end
    end
  end

  // prefetch the frame under the top for the next cycle's depth
  assign raddr = pcbs_pkg::IDX_W'(depth_next - pcbs_pkg::SCNT_W'(2));

  pcbs_ram #(
    .WIDTH (pcbs_pkg::FRAME_W),
    .DEPTH (pcbs_pkg::STACK_DEPTH)
  ) u_frames (
    .clk   (clk),
    .we    (we),
    .waddr (waddr),
    .wdata (wr_frame),
    .raddr (raddr),
    .rdata (rd_frame)
  );

  always_ff @(posedge clk) begin
    byp_frame <= wr_frame;
    top       <= top_next;
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      depth <= '0;
      ovf   <= 1'b0;
      byp   <= 1'b0;
    end else begin
      byp <= we && (waddr == raddr);
      if (fire && deq_item.last) begin
        depth <= '0;
        ovf   <= 1'b0;
      end else begin
        depth <= depth_next;
        ovf   <= ovf_next;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (fire && res) begin
      out_valid <= 1'b1;
    end else if (result_out.ready) begin
      out_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (fire && res) begin
      result_out.result_kind      <= res_kind;
      result_out.open_offset      <= res_open;
      result_out.mark_offset      <= res_mark;
      result_out.arg_count        <= res_args;
      result_out.stack_overflowed <= ovf_next;
    end
  end

  assign result_out.valid = out_valid;

  assert property (@(posedge clk) disable iff (rst)
    depth <= FULL)
    else $error("frame stack depth beyond capacity");

  assert property (@(posedge clk) disable iff (rst)
    fire && deq_item.last |=> depth == '0 && !ovf)
    else $error("stack not cleared after last byte");

  assert property (@(posedge clk) disable iff (rst)
    fire && deq_item.op == pcbs_pkg::OP_POP && depth != '0 |=>
      result_out.valid && result_out.result_kind == pcbs_pkg::KIND_PAREN)
    else $error("matched close paren gave no boundary item");

  assert property (@(posedge clk) disable iff (rst)
    fire && deq_item.op == pcbs_pkg::OP_PUSH && depth == FULL && !deq_item.last |=> ovf)
    else $error("overflow not recorded on full stack");

endmodule

// ----- verif/tb_paren_call_boundary_scanner.sv -----
`timescale 1ns / 1ps
module tb_paren_call_boundary_scanner;

  localparam logic [7:0] CH_TAB    = 8'h09;
  localparam logic [7:0] CH_NL     = 8'h0A;
  localparam logic [7:0] CH_CR     = 8'h0D;
  localparam logic [7:0] CH_SPACE  = 8'h20;
  localparam logic [7:0] CH_QUOTE  = 8'h22;
  localparam logic [7:0] CH_HASH   = 8'h23;
  localparam logic [7:0] CH_LPAREN = 8'h28;
  localparam logic [7:0] CH_RPAREN = 8'h29;
  localparam logic [7:0] CH_COMMA  = 8'h2C;
  localparam logic [7:0] CH_LSQ    = 8'h5B;
  localparam logic [7:0] CH_BSLASH = 8'h5C;
  localparam logic [7:0] CH_RSQ    = 8'h5D;
  localparam logic [7:0] CH_LCURLY = 8'h7B;
  localparam logic [7:0] CH_RCURLY = 8'h7D;

  localparam logic [pcbs_pkg::COUNT_BITS-1:0] CNT_MAX = {pcbs_pkg::COUNT_BITS{1'b1}};

  localparam int RANDOM_ITEMS = 500;
  localparam int CALM_LO      = 150;
  localparam int CALM_HI      = 350;
  localparam int HOLD_AT      = 450;
  localparam int HOLD_LEN     = 300;
  localparam int PAUSE_TEXT   = 12;
  localparam int DRAIN_CYCLES = 16;

  typedef struct {
    logic [7:0] b;
    logic       last;
    bit         hold_for_drain;
  } text_item_t;

  typedef struct packed {
    pcbs_pkg::kind_t            kind;
    logic [pcbs_pkg::OFF_W-1:0] open_off;
    logic [pcbs_pkg::OFF_W-1:0] mark_off;
    logic [pcbs_pkg::ARG_W-1:0] args;
    logic                       ovf;
  } boundary_t;

  logic clk;
  logic rst;

  pcbs_in_if  text_in ();
  pcbs_out_if result_out ();

  paren_call_boundary_scanner i_dut (
    .clk        (clk),
    .rst        (rst),
    .text_in    (text_in),
    .result_out (result_out)
  );

  text_item_t text_q[$];
  boundary_t  boundary_q[$];
  boundary_t  want;
  text_item_t next_item;
  bit         pause_req;
  bit         in_fire;
  bit         calm;
  bit         hold_done;
  int         hold_cnt;
  int         sent_count;
  int         mismatches;

  // scanner shadow state
  logic [pcbs_pkg::POS_BITS-1:0]   cur_pos;
  bit                              comment_on;
  bit                              quote_on;
  bit                              esc_pending;
  logic [pcbs_pkg::COUNT_BITS-1:0] sq_depth;
  logic [pcbs_pkg::COUNT_BITS-1:0] cu_depth;
  int                              depth;
  bit                              ovf_seen;
  pcbs_pkg::frame_t                frames[pcbs_pkg::STACK_DEPTH];

  initial begin
    clk = 1'b0;
    forever #4 clk = ~clk;
  end

  initial begin
    rst = 1'b1;
    text_in.valid       = 1'b0;
    text_in.text_byte   = '0;
    text_in.end_of_text = 1'b0;
    result_out.ready    = 1'b0;
    repeat (2) @(posedge clk);
    @(negedge clk);
    rst <= 1'b0;
  end

  function automatic bit is_space(input logic [7:0] c);
    return c == CH_SPACE || (c >= CH_TAB && c <= CH_CR);
  endfunction

  task automatic clear_scan();
    cur_pos     = '0;
    comment_on  = 1'b0;
    quote_on    = 1'b0;
    esc_pending = 1'b0;
    sq_depth    = '0;
    cu_depth    = '0;
    depth       = 0;
    ovf_seen    = 1'b0;
  endtask

  task automatic touch_top();
    if (depth > 0) frames[depth-1].tok_seen = 1'b1;
  endtask

  // Work out the boundary, if any, that one accepted byte causes
  task automatic track_byte(input logic [7:0] c, input logic last);
    boundary_t                     r;
    bit                            emit;
    int                            top;
    logic [pcbs_pkg::POS_BITS-1:0] nxt;
    emit = 1'b0;
    r    = '0;
    nxt  = cur_pos + 1'b1;
    if (c == CH_NL) begin
      emit       = 1'b1;
      r.kind     = pcbs_pkg::KIND_LINE;
      r.mark_off = pcbs_pkg::OFF_W'(nxt);
    end
    if (comment_on) begin
      if (c == CH_NL) comment_on = 1'b0;
    end else if (quote_on) begin
      if (esc_pending) esc_pending = 1'b0;
      else if (c == CH_BSLASH) esc_pending = 1'b1;
      else if (c == CH_QUOTE) quote_on = 1'b0;
    end else if (c == CH_HASH) begin
      comment_on = 1'b1;
    end else if (c == CH_QUOTE) begin
      quote_on = 1'b1;
      touch_top();
    end else if (c == CH_LPAREN) begin
      touch_top();
      if (depth >= pcbs_pkg::STACK_DEPTH) begin
        ovf_seen = 1'b1;
      end else begin
        frames[depth].open_pos = cur_pos;
        frames[depth].commas   = '0;
        frames[depth].square   = sq_depth;
        frames[depth].curly    = cu_depth;
        frames[depth].tok_seen = 1'b0;
        depth++;
      end
    end else if (c == CH_RPAREN) begin
      if (depth > 0) begin
        top        = depth - 1;
        emit       = 1'b1;
        r.kind     = pcbs_pkg::KIND_PAREN;
        r.open_off = pcbs_pkg::OFF_W'(frames[top].open_pos);
        r.mark_off = pcbs_pkg::OFF_W'(cur_pos);
        r.args     = frames[top].tok_seen ?
                     pcbs_pkg::ARG_W'(frames[top].commas) + 1'b1 : '0;
        depth      = top;
        touch_top();
      end
    end else begin
      if (c == CH_LSQ) begin
        if (sq_depth < CNT_MAX) sq_depth++;
      end else if (c == CH_RSQ) begin
        if (sq_depth > 0) sq_depth--;
      end else if (c == CH_LCURLY) begin
        if (cu_depth < CNT_MAX) cu_depth++;
      end else if (c == CH_RCURLY) begin
        if (cu_depth > 0) cu_depth--;
      end
      if (depth > 0) begin
        top = depth - 1;
        if (c == CH_COMMA && sq_depth == frames[top].square &&
            cu_depth == frames[top].curly) begin
          if (frames[top].commas < CNT_MAX) frames[top].commas++;
        end else if (!is_space(c)) begin
          frames[top].tok_seen = 1'b1;
        end
      end
    end
    if (emit) begin
      r.ovf = ovf_seen;
      boundary_q.push_back(r);
    end
    cur_pos = nxt;
    if (last) clear_scan();
  endtask

  task automatic push_byte(input logic [7:0] b);
    text_item_t it;
    it.b              = b;
    it.last           = 1'b0;
    it.hold_for_drain = pause_req;
    pause_req         = 1'b0;
    text_q.push_back(it);
  endtask

  task automatic push_text(input string s);
    for (int i = 0; i < s.len(); i++) push_byte(s[i]);
  endtask

  task automatic end_text();
    text_item_t it;
    it      = text_q.pop_back();
    it.last = 1'b1;
    text_q.push_back(it);
  endtask

  task automatic push_ident();
    int n;
    n = $urandom_range(1, 3);
    repeat (n) push_byte(8'($urandom_range(97, 122)));
  endtask

  // Mostly well-formed code with calls, strings and comments, salted with raw bytes
  task automatic gen_text(input bit deep);
    int n_open;
    int len;
    int pick;
    int k;
    n_open = 0;
    if (deep) begin
      len = $urandom_range(60, 72);
      for (k = 0; k < len; k++) begin
        push_byte(CH_LPAREN);
        if ($urandom_range(0, 1)) push_ident();
      end
      for (k = 0; k < len; k++) begin
        push_byte(CH_RPAREN);
        if ($urandom_range(0, 3) == 0) begin
          push_byte(CH_COMMA);
          push_ident();
        end
      end
    end else begin
      len = $urandom_range(8, 60);
      for (k = 0; k < len; k++) begin
        pick = $urandom_range(0, 99);
        if (pick < 20) begin
          push_ident();
        end else if (pick < 32) begin
          push_byte(CH_LPAREN);
          n_open++;
        end else if (pick < 44) begin
          push_byte(CH_RPAREN);
          if (n_open > 0) n_open--;
        end else if (pick < 52) begin
          push_byte(CH_COMMA);
        end else if (pick < 58) begin
          case ($urandom_range(0, 3))
            0: push_byte(CH_LSQ);
            1: push_byte(CH_RSQ);
            2: push_byte(CH_LCURLY);
            default: push_byte(CH_RCURLY);
          endcase
        end else if (pick < 66) begin
          if ($urandom_range(0, 1)) push_byte(CH_SPACE);
          else push_byte(8'($urandom_range(CH_TAB, CH_CR)));
        end else if (pick < 72) begin
          push_byte(CH_NL);
        end else if (pick < 78) begin
          push_byte(CH_QUOTE);
          repeat ($urandom_range(0, 6)) begin
            case ($urandom_range(0, 5))
              0: begin
                push_byte(CH_BSLASH);
                push_byte(8'($urandom_range(0, 255)));
              end
              1: push_byte(CH_LPAREN);
              2: push_byte(CH_COMMA);
              3: push_byte(CH_NL);
              default: push_ident();
            endcase
          end
          push_byte(CH_QUOTE);
        end else if (pick < 83) begin
          push_byte(CH_HASH);
          repeat ($urandom_range(0, 5)) begin
            if ($urandom_range(0, 2) == 0) push_byte(CH_LPAREN);
            else push_byte(8'($urandom_range(32, 126)));
          end
          push_byte(CH_NL);
        end else if (pick < 90) begin
          push_byte(8'($urandom_range(0, 255)));
        end else begin
          push_ident();
          push_byte(CH_LPAREN);
          push_ident();
          push_byte(CH_COMMA);
          push_ident();
          push_byte(CH_RPAREN);
        end
      end
      while (n_open > 0) begin
        push_byte(CH_RPAREN);
        n_open--;
      end
    end
    end_text();
  endtask

  initial begin
    int start;
    int n_texts;
    clear_scan();
    pause_req  = 1'b0;
    sent_count = 0;
    mismatches = 0;
    n_texts    = 0;

    // unmatched close, two arguments, line start
    push_text(")(b,c)\n");
    // blank frame and bare comma both give zero arguments
    push_text("(\t)(,)");
    // comment hides the paren and ends at the newline
    push_text("#(\n");
    // escaped quote, paren and newline inside a string
    push_text("\"\\\"(\n\"");
    // stray closer at depth zero, zero byte as token, nested commas not counted
    push_text("](");
    push_byte(8'h00);
    push_text("[,]{,})");
    // end of text with a frame still open, then a close that must find nothing
    push_byte(CH_LPAREN);
    push_byte(8'hFF);
    end_text();
    push_byte(CH_RPAREN);
    end_text();

    start = text_q.size();
    while (text_q.size() - start < RANDOM_ITEMS) begin
      if (n_texts == PAUSE_TEXT) pause_req = 1'b1;
      gen_text(n_texts % 15 == 7);
      n_texts++;
    end

    // overflow of the frame stack, then closes beyond the stack
    repeat (70) push_byte(CH_LPAREN);
    repeat (72) push_byte(CH_RPAREN);
    end_text();

    @(negedge rst);
    while (text_q.size() != 0 || text_in.valid) @(posedge clk);
    while (boundary_q.size() != 0) @(posedge clk);
    repeat (DRAIN_CYCLES) @(posedge clk);
    if (mismatches == 0) begin
      $display("No mismatches found");
    end else begin
      $display("Mismatches found");
    end
    $finish;
  end

  initial begin
    #5_000_000;
    $display("Mismatches found");
    $finish;
  end

  // sender: hold an offered item until taken, idle at random outside the calm stretch
  always @(negedge clk) begin
    if (rst) begin
      text_in.valid <= 1'b0;
    end else if (!text_in.valid || in_fire) begin
      calm = sent_count >= CALM_LO && sent_count < CALM_HI;
      if (text_q.size() != 0 &&
          !(text_q[0].hold_for_drain && boundary_q.size() != 0) &&
          (calm || $urandom_range(0, 99) >= 11)) begin
        next_item = text_q.pop_front();
        text_in.text_byte   <= next_item.b;
        text_in.end_of_text <= next_item.last;
        text_in.valid       <= 1'b1;
        sent_count++;
      end else begin
        text_in.valid <= 1'b0;
      end
    end
  end

  // receiver: random ready outside the calm stretch, plus one long hold-off while the sender keeps offering
  always @(negedge clk) begin
    if (rst) begin
      result_out.ready <= 1'b0;
      hold_cnt  = 0;
      hold_done = 1'b0;
    end else if (hold_cnt > 0) begin
      result_out.ready <= 1'b0;
      hold_cnt--;
    end else if (!hold_done && sent_count >= HOLD_AT) begin
      hold_done = 1'b1;
      hold_cnt  = HOLD_LEN - 1;
      result_out.ready <= 1'b0;
    end else begin
      result_out.ready <= calm || $urandom_range(0, 99) >= 11;
    end
  end

  always @(posedge clk) begin
    if (rst) begin
      in_fire <= 1'b0;
    end else begin
      in_fire <= text_in.valid && text_in.ready;
      if (result_out.valid && result_out.ready) begin
        if (boundary_q.size() == 0) begin
          mismatches++;
          if (mismatches <= 10)
            $display("unexpected result: kind=%0d open=%0d mark=%0d args=%0d ovf=%0b",
                     result_out.result_kind, result_out.open_offset,
                     result_out.mark_offset, result_out.arg_count,
                     result_out.stack_overflowed);
        end else begin
          want = boundary_q.pop_front();
          if (result_out.result_kind !== want.kind ||
              result_out.open_offset !== want.open_off ||
              result_out.mark_offset !== want.mark_off ||
              result_out.arg_count !== want.args ||
              result_out.stack_overflowed !== want.ovf) begin
            mismatches++;
            if (mismatches <= 10) begin
              $display("result mismatch: expected kind=%0d open=%0d mark=%0d args=%0d ovf=%0b",
                       want.kind, want.open_off, want.mark_off, want.args, want.ovf);
              $display("                 got      kind=%0d open=%0d mark=%0d args=%0d ovf=%0b",
                       result_out.result_kind, result_out.open_offset,
                       result_out.mark_offset, result_out.arg_count,
                       result_out.stack_overflowed);
            end
          end
        end
      end
      if (text_in.valid && text_in.ready)
        track_byte(text_in.text_byte, text_in.end_of_text);
    end
  end

endmodule
